// ===== rtl/wildcard_name_matcher_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard name matcher
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_NAME_MATCHER_ASSERT_SVH
`define WILDCARD_NAME_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WNM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wildcard_name_matcher: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WNM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wildcard_name_matcher: next-cycle check failed");

`endif

// ===== rtl/wnm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_pkg
// Shared types, constants and helpers of the wildcard name matcher.
// ----------------------------------------------------------------------------
package wnm_pkg;

  // Number of pattern bytes that the cell chain can hold.
  localparam int MAX_PATTERN = 32;
  // Width of the pattern length and of a position index (0 to MAX_PATTERN).
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QUERY_BYTE = 8'h3F;
  localparam logic [7:0] SLASH_BYTE = 8'h2F;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] FOLD_GAP   = 8'h20;

  // Request codes.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // Per-beat controls broadcast to every cell.
  typedef struct packed {
    logic clear;    // forget the stored pattern
    logic restart;  // return the active set to position zero only
    logic step;     // advance the active set over one name byte
  } cell_ctl_t;

  // Fold lower-case letters a to z onto upper case.
  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      r = c - FOLD_GAP;
    end
    return r;
  endfunction

endpackage

// ===== rtl/wnm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_req_if
// Request channel: pattern and name beats with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wnm_req_if;
  import wnm_pkg::*;

  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] ch;
  logic       match_all;

  modport source (output valid, output op, output ch, output match_all, input ready);
  modport sink (input valid, input op, input ch, input match_all, output ready);
endinterface

// ===== rtl/wnm_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_rsp_if
// Result channel: one beat per finished name.
// ----------------------------------------------------------------------------
interface wnm_rsp_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_too_long;

  modport source (output valid, output matched, output pattern_too_long, input ready);
  modport sink (input valid, input matched, input pattern_too_long, output ready);
endinterface

// ===== rtl/wildcard_name_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_name_matcher
// Anchored '*'/'?' wildcard matcher over a streamed name. Request beats may
// follow back to back while the rsp channel is not stalled; the result of an
// end-of-name beat is registered and shown on the rsp channel in the next
// cycle, and further beats are taken while it waits as long as rsp is
// drained. The pattern lives in a chain of MAX_PATTERN cells, one byte and
// one active bit per cell; the star-closure ripple along that chain is the
// longest path and sets the clock rate. A pattern beyond MAX_PATTERN bytes
// is flagged through pattern_too_long rather than truncated.
// ----------------------------------------------------------------------------
module wildcard_name_matcher import wnm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wnm_req_if.sink   req,
  wnm_rsp_if.source rsp
);

  logic                   acc;
  logic                   end_acc;
  logic                   term_byte;
  logic                   load;
  cell_ctl_t              ctl;
  logic [7:0]             name_fold;
  logic [LEN_W-1:0]       len;
  logic                   pat_closed;
  logic                   null_pat;
  logic                   overflow;
  logic                   tail_act;
  logic [MAX_PATTERN:0]   carry_v;
  logic [MAX_PATTERN:0]   adv_v;
  logic [MAX_PATTERN:0]   closed_all;
  logic                   match_now;
  logic                   matched;
  logic                   too_long;
  logic                   rsp_valid;

  // Beat decode.
  assign req.ready   = ~rsp_valid | rsp.ready;
  assign acc         = req.valid & req.ready;
  assign end_acc     = acc & (req.op == OP_END);
  assign term_byte   = (req.ch == SLASH_BYTE) | (req.ch == ZERO_BYTE);
  assign load        = acc & (req.op == OP_APPEND) & ~null_pat & ~pat_closed & ~term_byte
                       & (len < LEN_W'(MAX_PATTERN));
  assign ctl.clear   = acc & (req.op == OP_CLEAR);
  assign ctl.restart = acc & (req.op != OP_NAME);
  assign ctl.step    = acc & (req.op == OP_NAME);
  assign name_fold   = fold_byte(req.ch);

  // Pattern bookkeeping: length, terminator, null pattern and overflow.
  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      pat_closed <= 1'b0;
      null_pat   <= 1'b0;
      overflow   <= 1'b0;
    end else if (ctl.clear) begin
      len        <= '0;
      pat_closed <= 1'b0;
      null_pat   <= req.match_all;
      overflow   <= 1'b0;
    end else if (acc && req.op == OP_APPEND && !null_pat && !pat_closed) begin
      if (term_byte) begin
        pat_closed <= 1'b1;
      end else if (len < LEN_W'(MAX_PATTERN)) begin
        len <= len + LEN_W'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // The cell chain; nothing enters from the left of the first cell.
  assign carry_v[0] = 1'b0;
  assign adv_v[0]   = 1'b0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wnm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .head      (1'(i == 0)),
      .wr_en     (load & (len == LEN_W'(i))),
      .wr_byte   (req.ch),
      .name_byte (name_fold),
      .carry_in  (carry_v[i]),
      .adv_in    (adv_v[i]),
      .closed    (closed_all[i]),
      .carry_out (carry_v[i+1]),
      .adv_out   (adv_v[i+1])
    );
  end

  // Position just past the last cell: reached only by a full pattern.
  assign closed_all[MAX_PATTERN] = tail_act | carry_v[MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_act <= 1'b0;
    end else if (ctl.restart) begin
      tail_act <= 1'b0;
    end else if (ctl.step) begin
      tail_act <= adv_v[MAX_PATTERN];
    end
  end

  // The name matches when the closed active set reaches the pattern end.
  assign match_now = closed_all[len];

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (end_acc) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_acc) begin
      matched  <= null_pat | (~overflow & match_now);
      too_long <= ~null_pat & overflow;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.matched          = matched;
  assign rsp.pattern_too_long = too_long;

endmodule

// ===== rtl/wnm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_cell
// One pattern position: holds a pattern byte and the active bit of its
// position, and passes star closure and byte advances to its right neighbor.
// ----------------------------------------------------------------------------
module wnm_cell import wnm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  logic       head,
  input  logic       wr_en,
  input  logic [7:0] wr_byte,
  input  logic [7:0] name_byte,
  input  logic       carry_in,
  input  logic       adv_in,
  output logic       closed,
  output logic       carry_out,
  output logic       adv_out
);

  logic [7:0] pat;
  logic       is_star;
  logic       is_query;
  logic       used;
  logic       act;
  logic       act_next;
  logic       lit_eq;

  // Pattern byte storage, kept folded so a name byte compares directly.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat      <= fold_byte(wr_byte);
      is_star  <= (wr_byte == STAR_BYTE);
      is_query <= (wr_byte == QUERY_BYTE);
    end
  end

  // Star closure ripples in from the left; a used star passes it on.
  assign closed    = act | carry_in;
  assign carry_out = closed & used & is_star;
  assign lit_eq    = (pat == name_byte) & ~is_star & ~is_query;
  assign adv_out   = closed & used & (is_query | lit_eq);

  // A star keeps its own position; a match arrives from the left.
  assign act_next = adv_in | carry_out;

  // Occupancy and active bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      act  <= head;
    end else begin
      if (ctl.clear) begin
        used <= 1'b0;
      end else if (wr_en) begin
        used <= 1'b1;
      end
      if (ctl.restart) begin
        act <= head;
      end else if (ctl.step) begin
        act <= act_next;
      end
    end
  end

endmodule

// ===== rtl/wnm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_checker
// Port-level checks of the wildcard name matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "wildcard_name_matcher_assert.svh"

module wnm_checker import wnm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_op,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_matched,
  input logic       rsp_too_long
);

  // A stalled result beat stays offered and unchanged.
  `WNM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_matched) && $stable(rsp_too_long))

  // A fresh result only follows an accepted end-of-name beat.
  `WNM_ASSERT_SAME(a_rsp_cause, clk, rst, $rose(rsp_valid), $past(req_valid && req_ready && req_op == OP_END))

  // An overflowed pattern never reports a match.
  `WNM_ASSERT_SAME(a_rsp_excl, clk, rst, rsp_valid, !(rsp_matched && rsp_too_long))

  // With a result waiting and no room, no request beat is taken.
  `WNM_ASSERT_SAME(a_req_stall, clk, rst, rsp_valid && !rsp_ready, !req_ready)

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_op       (req.op),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_matched  (rsp.matched),
  .rsp_too_long (rsp.pattern_too_long)
);
